>>> sv/ppmb_pkg.sv
// Shared types, constants and register map for the peak programme meter.
// Used by the meter's front, lane and top modules and by the testbench; depends on nothing else.
package ppmb_pkg;

    // Word and field widths
    localparam int SAMPLE_W    = 24;
    localparam int LEVEL_W     = 24;
    localparam int COEFF_W     = 25;
    localparam int FRAC_W      = 24;
    localparam int NUM_SAMPLES = 8;
    localparam int NUM_STEREO  = 2;
    localparam int NUM_METERS  = NUM_SAMPLES + NUM_STEREO;
    localparam int PROD_W      = COEFF_W + LEVEL_W;

    // Default channel count limit
    localparam int MAX_CHANNELS_DEF = 8;

    // Mid/side gain of 0.707 in unsigned Q0.15
    localparam int LAW_SHIFT = 15;
    localparam logic [LAW_SHIFT-1:0] LAW_0707 = 15'd23167;

    // Register reset values
    localparam logic [3:0]         ACTIVE_RST = 4'd2;
    localparam logic               LAW_RST    = 1'b0;
    localparam logic [COEFF_W-1:0] RISE_RST   = 25'd1276199;
    localparam logic [COEFF_W-1:0] DROP_RST   = 25'd16776545;

    // Register map, word index into the APB space
    localparam int APB_ADDR_W = 4;
    typedef enum logic [1:0] {
        REG_ACTIVE = 2'd0,
        REG_LAW    = 2'd1,
        REG_RISE   = 2'd2,
        REG_DROP   = 2'd3
    } reg_idx_t;

    // Sequencer states: one frame at a time
    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MAG  = 2'd1,
        ST_MUL  = 2'd2,
        ST_UPD  = 2'd3
    } state_t;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [LEVEL_W-1:0]  level_t;

    // Controls handed to each ballistic lane
    typedef struct packed {
        logic mul_en;
        logic upd_en;
        logic active;
        logic clear;
    } lane_ctrl_t;

endpackage

>>> sv/ppmb_front.sv
// Magnitude stage: per-channel absolute values and scaled mid/side magnitudes.
// Depends on ppmb_pkg.
module ppmb_front (
    input  logic                                             clk,
    input  logic                                             en,
    input  logic                                             stereo_law,
    input  ppmb_pkg::sample_t [ppmb_pkg::NUM_SAMPLES-1:0]    sample,
    output ppmb_pkg::level_t  [ppmb_pkg::NUM_METERS-1:0]     mag_reg
);

    localparam int SUM_W  = ppmb_pkg::SAMPLE_W + 1;
    localparam int LPROD_W = SUM_W + ppmb_pkg::LAW_SHIFT;

    ppmb_pkg::level_t [ppmb_pkg::NUM_METERS-1:0] mag_next;
    logic [SUM_W-1:0]   sum_mid;
    logic [SUM_W-1:0]   sum_side;
    logic [SUM_W-1:0]   abs_mid;
    logic [SUM_W-1:0]   abs_side;
    logic [LPROD_W-1:0] law_mid;
    logic [LPROD_W-1:0] law_side;

    // Take channel magnitudes; full-scale negative maps to 2^23
    always_comb
    begin
        for (int i = 0; i < ppmb_pkg::NUM_SAMPLES; i++)
        begin
            mag_next[i] = sample[i][ppmb_pkg::SAMPLE_W-1] ? (~sample[i] + 1'b1) : sample[i];
        end

        sum_mid  = {sample[0][ppmb_pkg::SAMPLE_W-1], sample[0]}
                 + {sample[1][ppmb_pkg::SAMPLE_W-1], sample[1]};
        sum_side = {sample[0][ppmb_pkg::SAMPLE_W-1], sample[0]}
                 - {sample[1][ppmb_pkg::SAMPLE_W-1], sample[1]};
        abs_mid  = sum_mid[SUM_W-1]  ? (~sum_mid + 1'b1)  : sum_mid;
        abs_side = sum_side[SUM_W-1] ? (~sum_side + 1'b1) : sum_side;

        // Scale mid/side by one half or by 0.707
        law_mid  = LPROD_W'(abs_mid)  * LPROD_W'(ppmb_pkg::LAW_0707);
        law_side = LPROD_W'(abs_side) * LPROD_W'(ppmb_pkg::LAW_0707);
        if (stereo_law)
        begin
            mag_next[ppmb_pkg::NUM_SAMPLES]   =
                law_mid[ppmb_pkg::LAW_SHIFT +: ppmb_pkg::LEVEL_W];
            mag_next[ppmb_pkg::NUM_SAMPLES+1] =
                law_side[ppmb_pkg::LAW_SHIFT +: ppmb_pkg::LEVEL_W];
        end
        else
        begin
            mag_next[ppmb_pkg::NUM_SAMPLES]   = abs_mid[SUM_W-1:1];
            mag_next[ppmb_pkg::NUM_SAMPLES+1] = abs_side[SUM_W-1:1];
        end
    end

    // Hold magnitudes for the multiply and update steps
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= mag_next;
        end
    end

endmodule

>>> sv/ppmb_lane.sv
// One ballistic lane: rise/fall level tracking and block maximum of one meter.
// Depends on ppmb_pkg.
module ppmb_lane (
    input  logic                               clk,
    input  logic                               rst_n,
    input  ppmb_pkg::lane_ctrl_t               ctrl,
    input  ppmb_pkg::level_t                   mag,
    input  logic [ppmb_pkg::COEFF_W-1:0]       rise_coeff,
    input  logic [ppmb_pkg::COEFF_W-1:0]       drop_coeff,
    output ppmb_pkg::level_t                   peak_out
);

    localparam int PW = ppmb_pkg::PROD_W;
    localparam int LW = ppmb_pkg::LEVEL_W;
    localparam int FW = ppmb_pkg::FRAC_W;
    localparam int SW = PW - FW;

    ppmb_pkg::level_t level_reg;
    ppmb_pkg::level_t level_next;
    ppmb_pkg::level_t peak_reg;
    ppmb_pkg::level_t peak_next;
    logic [PW-1:0]    rise_prod_reg;
    logic [PW-1:0]    fall_prod_reg;
    logic [SW-1:0]    rise_step;
    logic [LW+1:0]    rise_sum;
    logic [SW-1:0]    fall_dec;

    // Form both products; at most one is used in the update step
    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            rise_prod_reg <= PW'(rise_coeff) * PW'(mag - level_reg);
            fall_prod_reg <= PW'(level_reg) * PW'(drop_coeff);
        end
    end

    // Next level and running maximum
    always_comb
    begin
        rise_step = rise_prod_reg[PW-1:FW];
        rise_sum  = (LW+2)'(level_reg) + (LW+2)'(rise_step);
        fall_dec  = fall_prod_reg[PW-1:FW];

        if (mag > level_reg)
        begin
            level_next = (rise_sum[LW+1:LW] != 2'b00) ? {LW{1'b1}} : rise_sum[LW-1:0];
        end
        else if (mag < level_reg)
        begin
            if (fall_dec < SW'(mag))
                level_next = mag;
            else if (fall_dec[SW-1:LW] != '0)
                level_next = {LW{1'b1}};
            else
                level_next = fall_dec[LW-1:0];
        end
        else
        begin
            level_next = level_reg;
        end

        peak_next = (level_next > peak_reg) ? level_next : peak_reg;
        peak_out  = ctrl.active ? peak_next : '0;
    end

    // Advance the level; clear the maximum once the block is reported
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            level_reg <= '0;
            peak_reg  <= '0;
        end
        else if (ctrl.upd_en)
        begin
            if (ctrl.active)
            begin
                level_reg <= level_next;
            end
            if (ctrl.clear)
                peak_reg <= '0;
            else if (ctrl.active)
                peak_reg <= peak_next;
        end
    end

endmodule

>>> sv/ppm_ballistic_meter.sv
// Peak programme meter: an accepted frame passes the magnitude, multiply and update
// steps in turn; the next frame is taken only after the update of the last one.
// Only a single frame is in flight through the lane multipliers at a time.
// A report word is valid from the update edge of an end-of-block frame and is held until
// taken; an end-of-block update waits while an earlier report is still pending.
// rst_n resets levels, maxima, registers and handshakes asynchronously.
module ppm_ballistic_meter #(
    parameter int MAX_CHANNELS = ppmb_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                  clk,
    input  logic                                  rst_n,
    // input stream
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [191:0]                          s_tdata,  // sample_0 .. sample_7
    input  logic                                  s_tlast,  // end_of_block
    // report stream
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [239:0]                          m_tdata,  // peak_0 .. peak_7, peak_mid, peak_side
    // configuration
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ppmb_pkg::APB_ADDR_W-1:0]       paddr,
    input  logic [31:0]                           pwdata,
    output logic [31:0]                           prdata,
    output logic                                  pready
);

    localparam int NS = ppmb_pkg::NUM_SAMPLES;
    localparam int NM = ppmb_pkg::NUM_METERS;
    localparam int NUM_LANES = (MAX_CHANNELS < NS) ? MAX_CHANNELS : NS;

    ppmb_pkg::state_t  state_reg;
    ppmb_pkg::state_t  state_next;
    logic [3:0]                     active_reg;
    logic                           law_reg;
    logic [ppmb_pkg::COEFF_W-1:0]   rise_reg;
    logic [ppmb_pkg::COEFF_W-1:0]   drop_reg;
    ppmb_pkg::sample_t [NS-1:0]     sample_reg;
    logic                           eob_reg;
    ppmb_pkg::level_t  [NM-1:0]     mag_reg;
    ppmb_pkg::level_t  [NM-1:0]     peak_word;
    ppmb_pkg::level_t  [NM-1:0]     out_reg;
    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic                           stall;
    logic                           update;
    logic                           stereo;
    logic                           wr_en;
    ppmb_pkg::reg_idx_t             wr_idx;
    ppmb_pkg::reg_idx_t             rd_idx;

    // Configuration registers
    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign wr_idx = ppmb_pkg::reg_idx_t'(paddr[3:2]);
    assign rd_idx = ppmb_pkg::reg_idx_t'(paddr[3:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ppmb_pkg::ACTIVE_RST;
            law_reg    <= ppmb_pkg::LAW_RST;
            rise_reg   <= ppmb_pkg::RISE_RST;
            drop_reg   <= ppmb_pkg::DROP_RST;
        end
        else if (wr_en)
        begin
            unique case (wr_idx)
                ppmb_pkg::REG_ACTIVE: active_reg <= pwdata[3:0];
                ppmb_pkg::REG_LAW:    law_reg    <= pwdata[0];
                ppmb_pkg::REG_RISE:   rise_reg   <= pwdata[ppmb_pkg::COEFF_W-1:0];
                ppmb_pkg::REG_DROP:   drop_reg   <= pwdata[ppmb_pkg::COEFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (rd_idx)
            ppmb_pkg::REG_ACTIVE: prdata = {28'd0, active_reg};
            ppmb_pkg::REG_LAW:    prdata = {31'd0, law_reg};
            ppmb_pkg::REG_RISE:   prdata = {7'd0, rise_reg};
            ppmb_pkg::REG_DROP:   prdata = {7'd0, drop_reg};
            default:              prdata = '0;
        endcase
    end

    assign stereo = (active_reg == 4'd2);

    // Sequencer next state
    assign stall  = eob_reg && out_valid_reg && !m_tready;
    assign update = (state_reg == ppmb_pkg::ST_UPD) && !stall;

    always_comb
    begin
        unique case (state_reg)
            ppmb_pkg::ST_IDLE: state_next = s_tvalid ? ppmb_pkg::ST_MAG : ppmb_pkg::ST_IDLE;
            ppmb_pkg::ST_MAG:  state_next = ppmb_pkg::ST_MUL;
            ppmb_pkg::ST_MUL:  state_next = ppmb_pkg::ST_UPD;
            ppmb_pkg::ST_UPD:  state_next = stall ? ppmb_pkg::ST_UPD : ppmb_pkg::ST_IDLE;
            default:           state_next = ppmb_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ppmb_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Sequencer outputs
    always_comb
    begin
        s_tready = 1'b0;
        unique case (state_reg)
            ppmb_pkg::ST_IDLE: s_tready = 1'b1;
            ppmb_pkg::ST_MAG,
            ppmb_pkg::ST_MUL,
            ppmb_pkg::ST_UPD:  s_tready = 1'b0;
            default:           s_tready = 1'b0;
        endcase
    end

    // Capture the accepted word
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            for (int i = 0; i < NS; i++)
            begin
                sample_reg[i] <= s_tdata[i*ppmb_pkg::SAMPLE_W +: ppmb_pkg::SAMPLE_W];
            end
            eob_reg <= s_tlast;
        end
    end

    ppmb_front u_front (
        .clk        (clk),
        .en         (state_reg == ppmb_pkg::ST_MAG),
        .stereo_law (law_reg),
        .sample     (sample_reg),
        .mag_reg    (mag_reg)
    );

    // Channel lanes
    for (genvar g = 0; g < NS; g++)
    begin : g_chan
        if (g < NUM_LANES)
        begin : g_lane
            ppmb_pkg::lane_ctrl_t ctrl;
            assign ctrl.mul_en = (state_reg == ppmb_pkg::ST_MUL);
            assign ctrl.upd_en = update;
            assign ctrl.active = (active_reg > 4'(g));
            assign ctrl.clear  = eob_reg;

            ppmb_lane u_lane (
                .clk        (clk),
                .rst_n      (rst_n),
                .ctrl       (ctrl),
                .mag        (mag_reg[g]),
                .rise_coeff (rise_reg),
                .drop_coeff (drop_reg),
                .peak_out   (peak_word[g])
            );
        end
        else
        begin : g_none
            assign peak_word[g] = '0;
        end
    end

    // Mid and side lanes
    for (genvar g = NS; g < NM; g++)
    begin : g_ms
        ppmb_pkg::lane_ctrl_t ctrl;
        assign ctrl.mul_en = (state_reg == ppmb_pkg::ST_MUL);
        assign ctrl.upd_en = update;
        assign ctrl.active = stereo;
        assign ctrl.clear  = eob_reg;

        ppmb_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .mag        (mag_reg[g]),
            .rise_coeff (rise_reg),
            .drop_coeff (drop_reg),
            .peak_out   (peak_word[g])
        );
    end

    // Merge lane maxima into the report word
    always_ff @(posedge clk)
    begin
        if (update && eob_reg)
        begin
            out_reg <= peak_word;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (m_tvalid && m_tready)
            out_valid_next = 1'b0;
        if (update && eob_reg)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;

endmodule

>>> sv/ppmb_checker.sv
// Port-level checks for the peak programme meter, bound to the top level.
// Depends on ppm_ballistic_meter, which the bind below names.
module ppmb_checker (
    input logic                             clk,
    input logic                             rst_n,
    input logic                             s_tvalid,
    input logic                             s_tready,
    input logic                             s_tlast,
    input logic                             m_tvalid,
    input logic                             m_tready,
    input logic [239:0]                     m_tdata
);

    // Hold a pending report word steady
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("report word changed while stalled");

    // Take one frame at a time
    a_one_frame: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second frame taken while one is in flight");

    // An end-of-block frame taken while no report is pending raises a report
    a_report: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && s_tlast && !m_tvalid |-> ##4 m_tvalid)
        else $error("end-of-block report missing");

    // Frames without an end-of-block mark give no report
    a_no_report: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !s_tlast && !m_tvalid |-> ##4 !m_tvalid)
        else $error("report from a frame without end of block");

endmodule

bind ppm_ballistic_meter ppmb_checker u_ppmb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

>>> bench/tb_ppm_ballistic_meter.sv
// Testbench for the peak programme meter: drives audio frames and register writes,
// predicts every report word and checks it field by field against the block.
// Depends on ppmb_pkg and ppm_ballistic_meter.
module tb_ppm_ballistic_meter;
    timeunit 1ns;
    timeprecision 1ps;

    import ppmb_pkg::*;

    localparam int IDLE_LIMIT    = 1000;
    localparam int SETTLE_CYCLES = 12;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_FRAMES  = 200;

    localparam logic [COEFF_W-1:0] COEFF_ONE = 25'h1000000;
    localparam logic [COEFF_W-1:0] COEFF_TOP = 25'h1FFFFFF;
    localparam level_t             LEVEL_TOP = 24'hFFFFFF;
    localparam sample_t            POS_FULL  = 24'h7FFFFF;
    localparam sample_t            NEG_FULL  = 24'h800000;

    typedef logic [NUM_SAMPLES*SAMPLE_W-1:0] frame_t;
    typedef logic [NUM_METERS*LEVEL_W-1:0]   report_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    frame_t                 s_tdata  = '0;   // sample_0 .. sample_7
    logic                   s_tlast  = 1'b0; // end_of_block
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    report_t                m_tdata;         // peak_0 .. peak_7, peak_mid, peak_side
    logic                   psel     = 1'b0;
    logic                   penable  = 1'b0;
    logic                   pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0]  paddr    = '0;
    logic [31:0]            pwdata   = '0;
    logic [31:0]            prdata;
    logic                   pready;

    // Register copy and meter state of the predictor
    logic [3:0]         cfg_channels = ACTIVE_RST;
    logic               cfg_law      = LAW_RST;
    logic [COEFF_W-1:0] cfg_rise     = RISE_RST;
    logic [COEFF_W-1:0] cfg_drop     = DROP_RST;
    level_t             chan_level[NUM_SAMPLES];
    level_t             chan_peak[NUM_SAMPLES];
    level_t             ms_level[NUM_STEREO];
    level_t             ms_peak[NUM_STEREO];

    report_t pending_reports[$];
    int      mismatch_count = 0;
    int      idle_cycles    = 0;
    int      ready_hold     = 0;
    int      rx_calm        = 0;
    bit      steady_tx      = 1'b0;

    ppm_ballistic_meter uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #5 clk = ~clk;

    // ---------------------------------------------------------------- predictor

    function automatic level_t ballistic_next(level_t lv, level_t mag);
        logic [63:0] acc;
        if (mag > lv)
        begin
            acc = 64'(lv) + ((64'(cfg_rise) * 64'(mag - lv)) >> FRAC_W);
        end
        else if (mag < lv)
        begin
            acc = (64'(lv) * 64'(cfg_drop)) >> FRAC_W;
            if (acc < 64'(mag))
                acc = 64'(mag);
        end
        else
        begin
            acc = 64'(lv);
        end
        return (acc > 64'(LEVEL_TOP)) ? LEVEL_TOP : acc[LEVEL_W-1:0];
    endfunction

    function automatic level_t stereo_mag(int sum);
        logic [63:0] m;
        m = 64'(sum < 0 ? -sum : sum);
        if (cfg_law)
            m = (m * 64'(LAW_0707)) >> LAW_SHIFT;
        else
            m = m >> 1;
        return m[LEVEL_W-1:0];
    endfunction

    // Advance every active meter by one frame; queue a report word on end of block
    task automatic meter_frame(frame_t f, logic eob);
        int      n;
        int      s;
        int      l;
        int      r;
        bit      stereo;
        level_t  mag;
        level_t  ms_in[NUM_STEREO];
        report_t rep;
        n = (cfg_channels > NUM_SAMPLES) ? NUM_SAMPLES : int'(cfg_channels);
        stereo = (cfg_channels == 4'd2);
        for (int i = 0; i < n; i++)
        begin
            s = int'($signed(f[i*SAMPLE_W +: SAMPLE_W]));
            mag = level_t'(s < 0 ? -s : s);
            chan_level[i] = ballistic_next(chan_level[i], mag);
            if (chan_level[i] > chan_peak[i])
                chan_peak[i] = chan_level[i];
        end
        if (stereo)
        begin
            l = int'($signed(f[0 +: SAMPLE_W]));
            r = int'($signed(f[SAMPLE_W +: SAMPLE_W]));
            ms_in[0] = stereo_mag(l + r);
            ms_in[1] = stereo_mag(l - r);
            for (int i = 0; i < NUM_STEREO; i++)
            begin
                ms_level[i] = ballistic_next(ms_level[i], ms_in[i]);
                if (ms_level[i] > ms_peak[i])
                    ms_peak[i] = ms_level[i];
            end
        end
        if (eob)
        begin
            for (int i = 0; i < NUM_SAMPLES; i++)
                rep[i*LEVEL_W +: LEVEL_W] = (i < n) ? chan_peak[i] : '0;
            for (int i = 0; i < NUM_STEREO; i++)
                rep[(NUM_SAMPLES+i)*LEVEL_W +: LEVEL_W] = stereo ? ms_peak[i] : '0;
            pending_reports.push_back(rep);
            // clear the block maxima once reported
            for (int i = 0; i < NUM_SAMPLES; i++)
                chan_peak[i] = '0;
            for (int i = 0; i < NUM_STEREO; i++)
                ms_peak[i] = '0;
        end
    endtask

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(string what);
        mismatch_count++;
        $display("%0t ns mismatch: %s", $time, what);
    endtask

    // Compare each report word with the oldest prediction; draw the next stall
    always @(posedge clk)
    begin : check_reports
        report_t want;
        string   name;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (rx_calm > 0)
            begin
                rx_calm--;
                ready_hold = 0;
            end
            else
            begin
                if ($urandom_range(0, 15) == 0)
                    rx_calm = 12;
                ready_hold = $urandom_range(0, 11);
            end
            if (pending_reports.size() == 0)
            begin
                report_mismatch("report word with no block pending");
            end
            else
            begin
                want = pending_reports.pop_front();
                for (int i = 0; i < NUM_METERS; i++)
                begin
                    if (m_tdata[i*LEVEL_W +: LEVEL_W] !== want[i*LEVEL_W +: LEVEL_W])
                    begin
                        name = (i < NUM_SAMPLES) ? $sformatf("peak_%0d", i)
                             : (i == NUM_SAMPLES) ? "peak_mid" : "peak_side";
                        report_mismatch($sformatf("%s got %h want %h", name,
                            m_tdata[i*LEVEL_W +: LEVEL_W], want[i*LEVEL_W +: LEVEL_W]));
                    end
                end
            end
        end
    end

    // Hold off the report stream while a stall is running
    always @(negedge clk)
    begin
        if (ready_hold > 0)
        begin
            m_tready = 1'b0;
            if (m_tvalid)
                ready_hold--;
        end
        else
        begin
            m_tready = 1'b1;
        end
    end

    // End the run if nothing moves for too long
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // ---------------------------------------------------------------- drivers

    task automatic apb_write(reg_idx_t idx, logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = value;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
        case (idx)
            REG_ACTIVE: cfg_channels = value[3:0];
            REG_LAW:    cfg_law      = value[0];
            REG_RISE:   cfg_rise     = value[COEFF_W-1:0];
            REG_DROP:   cfg_drop     = value[COEFF_W-1:0];
            default:    ;
        endcase
    endtask

    task automatic configure(logic [3:0] channels, logic law,
                             logic [COEFF_W-1:0] rise, logic [COEFF_W-1:0] drop);
        apb_write(REG_ACTIVE, 32'(channels));
        apb_write(REG_LAW, 32'(law));
        apb_write(REG_RISE, 32'(rise));
        apb_write(REG_DROP, 32'(drop));
    endtask

    // Send one frame; called and returns just after a falling edge
    task automatic send_frame(frame_t f, logic eob);
        int gap;
        gap = steady_tx ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tdata  = f;
        s_tlast  = eob;
        s_tvalid = 1'b1;
        do @(posedge clk); while (!s_tready);
        meter_frame(f, eob);
        @(negedge clk);
    endtask

    // Stop sending, wait for every report word, then let the pipeline drain
    task automatic wait_reports_done();
        s_tvalid = 1'b0;
        while (pending_reports.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic frame_t fill_frame(sample_t left, sample_t right, sample_t rest);
        frame_t f;
        for (int i = 0; i < NUM_SAMPLES; i++)
            f[i*SAMPLE_W +: SAMPLE_W] = rest;
        f[0 +: SAMPLE_W]        = left;
        f[SAMPLE_W +: SAMPLE_W] = right;
        return f;
    endfunction

    function automatic sample_t draw_sample();
        int v;
        v = $urandom_range(0, 255);
        case ($urandom_range(0, 9))
            0:       return POS_FULL;
            1:       return NEG_FULL;
            2:       return '0;
            3:       return $urandom_range(0, 1) ? sample_t'(-v) : sample_t'(v);
            default: return sample_t'($urandom());
        endcase
    endfunction

    // Mostly fresh samples; sometimes a repeated frame or a matched/opposed pair
    function automatic frame_t draw_frame(frame_t prev);
        frame_t f;
        if ($urandom_range(0, 7) == 0)
            return prev;
        for (int i = 0; i < NUM_SAMPLES; i++)
            f[i*SAMPLE_W +: SAMPLE_W] = draw_sample();
        case ($urandom_range(0, 7))
            0:       f[SAMPLE_W +: SAMPLE_W] = f[0 +: SAMPLE_W];
            1:       f[SAMPLE_W +: SAMPLE_W] = -f[0 +: SAMPLE_W];
            default: ;
        endcase
        return f;
    endfunction

    function automatic logic [COEFF_W-1:0] draw_coeff(bit for_drop);
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return COEFF_ONE;
            2:       return COEFF_TOP;
            3:       return COEFF_W'($urandom());
            default: return for_drop ? COEFF_W'($urandom_range(16000000, 16777216))
                                     : COEFF_W'($urandom_range(1, 4000000));
        endcase
    endfunction

    // ---------------------------------------------------------------- tests

    // Reset register values, levels starting from zero, full-scale samples
    task automatic test_default_setting();
        send_frame(fill_frame(POS_FULL, NEG_FULL, POS_FULL), 1'b0);
        send_frame(fill_frame(NEG_FULL, POS_FULL, NEG_FULL), 1'b1);
        send_frame(fill_frame('0, '0, '0), 1'b1);
        wait_reports_done();
    endtask

    // All eight channels, no channels, and a count beyond the limit
    task automatic test_channel_counts();
        configure(4'd8, 1'b1, COEFF_ONE, '0);
        send_frame(fill_frame(NEG_FULL, NEG_FULL, NEG_FULL), 1'b0);
        send_frame(fill_frame(POS_FULL, POS_FULL, POS_FULL), 1'b0);
        send_frame(fill_frame('0, '0, '0), 1'b1);
        wait_reports_done();
        configure(4'd0, 1'b0, COEFF_ONE, COEFF_ONE);
        send_frame(fill_frame(POS_FULL, NEG_FULL, POS_FULL), 1'b1);
        wait_reports_done();
        apb_write(REG_ACTIVE, 32'd15);
        send_frame(fill_frame(NEG_FULL, 24'h123456, POS_FULL), 1'b1);
        wait_reports_done();
    endtask

    // Coefficients above one drive channel and mid/side levels into saturation
    task automatic test_saturation();
        configure(4'd2, 1'b1, COEFF_TOP, COEFF_TOP);
        send_frame(fill_frame(POS_FULL, POS_FULL, '0), 1'b0);
        send_frame(fill_frame(NEG_FULL, POS_FULL, '0), 1'b0);
        send_frame(fill_frame(24'h000100, 24'h000100, '0), 1'b0);
        send_frame(fill_frame('0, '0, '0), 1'b1);
        wait_reports_done();
    endtask

    // Mono holds the mid/side meters; zero coefficients freeze rises
    task automatic test_mono_hold();
        configure(4'd1, 1'b0, RISE_RST, DROP_RST);
        send_frame(fill_frame(POS_FULL, NEG_FULL, NEG_FULL), 1'b1);
        wait_reports_done();
        configure(4'd2, 1'b0, '0, '0);
        send_frame(fill_frame(POS_FULL, NEG_FULL, '0), 1'b0);
        send_frame(fill_frame(24'h000001, '0, '0), 1'b1);
        wait_reports_done();
    endtask

    // Random blocks of frames over several register settings
    task automatic test_random_blocks();
        frame_t     f;
        int         block_len;
        int         sent;
        logic [3:0] channels;
        f = '0;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            if (phase == 0)
                channels = 4'd2;
            else if (phase == 1)
                channels = 4'd8;
            else
                channels = $urandom_range(0, 1) ? 4'd2 : 4'($urandom_range(0, 15));
            configure(channels, 1'($urandom_range(0, 1)), draw_coeff(1'b0), draw_coeff(1'b1));
            sent = 0;
            while (sent < PHASE_FRAMES)
            begin
                block_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                        : $urandom_range(1, 12);
                steady_tx = ($urandom_range(0, 3) == 0);
                for (int k = 0; k < block_len; k++)
                begin
                    f = draw_frame(f);
                    send_frame(f, k == block_len - 1);
                end
                sent += block_len;
                // occasionally hold the sender until every report is back
                if ($urandom_range(0, 15) == 0)
                    wait_reports_done();
            end
            steady_tx = 1'b0;
            wait_reports_done();
        end
    endtask

    // ---------------------------------------------------------------- sequence

    initial
    begin
        for (int i = 0; i < NUM_SAMPLES; i++)
        begin
            chan_level[i] = '0;
            chan_peak[i]  = '0;
        end
        for (int i = 0; i < NUM_STEREO; i++)
        begin
            ms_level[i] = '0;
            ms_peak[i]  = '0;
        end
        repeat (8) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_default_setting();
        test_channel_counts();
        test_saturation();
        test_mono_hold();
        test_random_blocks();

        if (mismatch_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
sv/ppmb_pkg.sv
sv/ppmb_front.sv
sv/ppmb_lane.sv
sv/ppm_ballistic_meter.sv
sv/ppmb_checker.sv
bench/tb_ppm_ballistic_meter.sv
